/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clock and gated by reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PLB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never hold outside reset.
`define PLB_NEVER(label, cond, msg) \
   `PLB_ASSERT(label, !(cond), msg)

`endif

/* design/plb_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list buffer package
// Sizes, command and status codes, and the word types passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plb_pkg;

   localparam int CAPACITY    = 16;
   localparam int MAX_RUN     = 16;
   localparam int LEN_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int POS_W       = 8;
   localparam int VAL_W       = 32;
   localparam int CMP_W       = POS_W + 1;
   localparam int OUT_CNT_W   = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] CMD_INS_FIRST = 3'd0;
   localparam logic [2:0] CMD_INS_LAST  = 3'd1;
   localparam logic [2:0] CMD_INS_AT    = 3'd2;
   localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
   localparam logic [2:0] CMD_DEL_LAST  = 3'd4;
   localparam logic [2:0] CMD_DEL_AT    = 3'd5;
   localparam logic [2:0] CMD_COUNT     = 3'd6;
   localparam logic [2:0] CMD_READ_ALL  = 3'd7;

   localparam logic [1:0] KIND_INS  = 2'd0;
   localparam logic [1:0] KIND_DEL  = 2'd1;
   localparam logic [1:0] KIND_CNT  = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   localparam logic [1:0] SEL_FIRST = 2'd0;
   localparam logic [1:0] SEL_LAST  = 2'd1;
   localparam logic [1:0] SEL_POS   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]              kind;
      logic [1:0]              sel;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } cmd_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] read_value;
      logic [OUT_CNT_W-1:0]    read_position;
      logic [OUT_CNT_W-1:0]    entry_count;
      logic                    last_of_run;
   } rsp_type;

endpackage

/* design/plb_front.sv */
// ----------------------------------------------------------------------------
// Positional list buffer front end
// Accepts request words, classifies each command and queues it for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plb_front import plb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [2:0]              req_command,
   input  logic signed [VAL_W-1:0] req_element_value,
   input  logic [POS_W-1:0]        req_position,
   output logic                    cmd_valid,
   output cmd_type                 cmd_head,
   input  logic                    cmd_pop
);

   cmd_type            decoded;
   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      decoded.value    = req_element_value;
      decoded.position = req_position;
      case (req_command)
         CMD_INS_FIRST: begin
            decoded.kind = KIND_INS;
            decoded.sel  = SEL_FIRST;
         end
         CMD_INS_LAST: begin
            decoded.kind = KIND_INS;
            decoded.sel  = SEL_LAST;
         end
         CMD_INS_AT: begin
            decoded.kind = KIND_INS;
            decoded.sel  = SEL_POS;
         end
         CMD_DEL_FIRST: begin
            decoded.kind = KIND_DEL;
            decoded.sel  = SEL_FIRST;
         end
         CMD_DEL_LAST: begin
            decoded.kind = KIND_DEL;
            decoded.sel  = SEL_LAST;
         end
         CMD_DEL_AT: begin
            decoded.kind = KIND_DEL;
            decoded.sel  = SEL_POS;
         end
         CMD_COUNT: begin
            decoded.kind = KIND_CNT;
            decoded.sel  = SEL_FIRST;
         end
         default: begin
            decoded.kind = KIND_READ;
            decoded.sel  = SEL_FIRST;
         end
      endcase
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

/* design/plb_rsp_queue.sv */
// ----------------------------------------------------------------------------
// Positional list buffer response queue
// Holds result words from the back end until the consumer pops them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plb_rsp_queue import plb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   input  rsp_type rsp_data,
   output logic    rsp_full,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_head
);

   rsp_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign rsp_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_head = queue_ff[rd_ptr_ff];
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= rsp_data;
      end
   end

endmodule

/* design/plb_back.sv */
// ----------------------------------------------------------------------------
// Positional list buffer back end
// Holds the list, carries out queued commands and produces the result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plb_back import plb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   logic signed [VAL_W-1:0] store_ff [CAPACITY];
   logic signed [VAL_W-1:0] store_in [CAPACITY];
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    go;
   logic [CMP_W-1:0]        len_w;
   logic [CMP_W-1:0]        target;
   logic [CMP_W-1:0]        run_n;
   logic [CMP_W-1:0]        rd_pos;
   logic [IDX_W-1:0]        k;
   logic [1:0]              status;
   logic                    run_last;

   always_comb begin
      go       = cmd_valid && !rsp_full;
      len_w    = CMP_W'(len_ff);
      run_n    = (len_w < CMP_W'(MAX_RUN)) ? len_w : CMP_W'(MAX_RUN);
      rd_pos   = CMP_W'(rd_idx_ff) + CMP_W'(1);
      run_last = (rd_pos == run_n);

      case (cmd_head.sel)
         SEL_FIRST: target = CMP_W'(1);
         SEL_LAST:  target = len_w + CMP_W'(cmd_head.kind == KIND_INS);
         default:   target = CMP_W'(cmd_head.position);
      endcase
      k = IDX_W'(target - CMP_W'(1));

      status = ST_OK;
      if (cmd_head.kind == KIND_INS) begin
         if (target == '0 || target > len_w + CMP_W'(1)) begin
            status = ST_BADPOS;
         end else if (len_w >= CMP_W'(CAPACITY)) begin
            status = ST_FULL;
         end
      end else if (cmd_head.kind == KIND_DEL) begin
         if (len_ff == '0) begin
            status = ST_EMPTY;
         end else if (target == '0 || target > len_w) begin
            status = ST_BADPOS;
         end
      end

      store_in  = store_ff;
      len_in    = len_ff;
      rd_idx_in = rd_idx_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = '0;

      if (go) begin
         rsp_push = 1'b1;
         if (cmd_head.kind == KIND_READ) begin
            if (len_ff == '0) begin
               rsp_data.status      = ST_EMPTY;
               rsp_data.last_of_run = 1'b1;
               cmd_pop              = 1'b1;
            end else begin
               rsp_data.status        = ST_OK;
               rsp_data.read_value    = store_ff[rd_idx_ff];
               rsp_data.read_position = OUT_CNT_W'(rd_pos);
               rsp_data.entry_count   = OUT_CNT_W'(len_ff);
               rsp_data.last_of_run   = run_last;
               if (run_last) begin
                  rd_idx_in = '0;
                  cmd_pop   = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
         end else begin
            cmd_pop = 1'b1;
            if (status == ST_OK && cmd_head.kind == KIND_INS) begin
               for (int i = 1; i < CAPACITY; i++) begin
                  if (IDX_W'(i) > k) begin
                     store_in[i] = store_ff[i-1];
                  end
               end
               store_in[k] = cmd_head.value;
               len_in      = len_ff + LEN_W'(1);
            end else if (status == ST_OK && cmd_head.kind == KIND_DEL) begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (IDX_W'(i) >= k) begin
                     store_in[i] = store_ff[i+1];
                  end
               end
               len_in = len_ff - LEN_W'(1);
            end
            rsp_data.status      = status;
            rsp_data.entry_count = OUT_CNT_W'(len_in);
            rsp_data.last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         len_ff    <= len_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   `PLB_NEVER(a_len_bound, len_ff > LEN_W'(CAPACITY), "list length above capacity")
   `PLB_ASSERT(a_run_head, (rd_idx_ff != '0) |-> (cmd_valid && cmd_head.kind == KIND_READ), "read run without read command")
   `PLB_ASSERT(a_pop_last, cmd_pop |-> (rsp_push && rsp_data.last_of_run), "command retired without final word")
   `PLB_ASSERT(a_len_change, (len_ff != $past(len_ff)) |-> $past(cmd_pop), "length changed without a command")

endmodule

/* design/positional_list_buffer.sv */
// A pushed word is stored in the front queue; the back end serves its head and puts
// result words in the response queue, stalling while that queue is full. Insert,
// delete and count give one word each; read-all reads one entry per word in order.
// Both sides are four-word queues, so the front can accept words while results wait.
// Reset clears the list length and both queues; entry contents are not cleared.
// ----------------------------------------------------------------------------
// Positional list buffer
// Bounded ordered list of signed words with positional insert, delete and read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_buffer import plb_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [2:0]                  req_command,
   input  logic signed [VAL_W-1:0]     req_element_value,
   input  logic [POS_W-1:0]            req_position,
   output logic                        empty,
   input  logic                        pop,
   output logic [1:0]                  rsp_status,
   output logic signed [VAL_W-1:0]     rsp_read_value,
   output logic [OUT_CNT_W-1:0]        rsp_read_position,
   output logic [OUT_CNT_W-1:0]        rsp_entry_count,
   output logic                        rsp_last_of_run
);

   logic    cmd_valid;
   cmd_type cmd_head;
   logic    cmd_pop;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type rsp_data;
   rsp_type rsp_head;

   plb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_element_value (req_element_value),
      .req_position      (req_position),
      .cmd_valid         (cmd_valid),
      .cmd_head          (cmd_head),
      .cmd_pop           (cmd_pop)
   );

   plb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   plb_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_data (rsp_data),
      .rsp_full (rsp_full),
      .pop      (pop),
      .empty    (empty),
      .rsp_head (rsp_head)
   );

   assign rsp_status        = rsp_head.status;
   assign rsp_read_value    = rsp_head.read_value;
   assign rsp_read_position = rsp_head.read_position;
   assign rsp_entry_count   = rsp_head.entry_count;
   assign rsp_last_of_run   = rsp_head.last_of_run;

endmodule

/* dv/plb_list_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list buffer monitor
// Watches both queue interfaces of the list buffer and keeps its own copy of
// the list. It works out the result words for every accepted command and
// compares each popped word, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------

module plb_list_monitor import plb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    full,
   input  logic [2:0]              req_command,
   input  logic signed [VAL_W-1:0] req_element_value,
   input  logic [POS_W-1:0]        req_position,
   input  logic                    empty,
   input  logic                    pop,
   input  logic [1:0]              rsp_status,
   input  logic signed [VAL_W-1:0] rsp_read_value,
   input  logic [OUT_CNT_W-1:0]    rsp_read_position,
   input  logic [OUT_CNT_W-1:0]    rsp_entry_count,
   input  logic                    rsp_last_of_run,
   output int                      mismatch_count,
   output int                      rsp_due_count
);

   logic signed [VAL_W-1:0] list_entries [CAPACITY];
   int                      list_len;
   rsp_type                 rsp_due_q [$];

   function automatic logic [1:0] list_insert(int place, logic signed [VAL_W-1:0] value);
      int i;
      if (place < 1 || place > list_len + 1) return ST_BADPOS;
      if (list_len >= CAPACITY) return ST_FULL;
      for (i = list_len; i >= place; i--) list_entries[i] = list_entries[i - 1];
      list_entries[place - 1] = value;
      list_len++;
      return ST_OK;
   endfunction

   function automatic logic [1:0] list_delete(int place);
      int i;
      if (list_len == 0) return ST_EMPTY;
      if (place < 1 || place > list_len) return ST_BADPOS;
      for (i = place; i < list_len; i++) list_entries[i - 1] = list_entries[i];
      list_len--;
      return ST_OK;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] status, logic signed [VAL_W-1:0] value,
                                        int place, logic last);
      rsp_type word;
      word.status        = status;
      word.read_value    = value;
      word.read_position = OUT_CNT_W'(place);
      word.entry_count   = OUT_CNT_W'(list_len);
      word.last_of_run   = last;
      return word;
   endfunction

   task automatic apply_command(logic [2:0] command, logic signed [VAL_W-1:0] value,
                                logic [POS_W-1:0] position);
      logic [1:0] status;
      int         run_len;
      int         i;
      case (command)
         CMD_INS_FIRST: status = list_insert(1, value);
         CMD_INS_LAST:  status = list_insert(list_len + 1, value);
         CMD_INS_AT:    status = list_insert(int'(position), value);
         CMD_DEL_FIRST: status = list_delete(1);
         CMD_DEL_LAST:  status = list_delete(list_len);
         CMD_DEL_AT:    status = list_delete(int'(position));
         default:       status = ST_OK;
      endcase
      if (command != CMD_READ_ALL) begin
         rsp_due_q.push_back(make_rsp(status, '0, 0, 1'b1));
      end else if (list_len == 0) begin
         rsp_due_q.push_back(make_rsp(ST_EMPTY, '0, 0, 1'b1));
      end else begin
         run_len = (list_len < MAX_RUN) ? list_len : MAX_RUN;
         for (i = 0; i < run_len; i++) begin
            rsp_due_q.push_back(make_rsp(ST_OK, list_entries[i], i + 1, i + 1 == run_len));
         end
      end
   endtask

   task automatic check_field(string field, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         list_len = 0;
         rsp_due_q.delete();
         mismatch_count = 0;
      end else begin
         if (pop && !empty) begin
            if (rsp_due_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: word popped with none owed, expected nothing, got %0d %0d %0d %0d %0b",
                        $time, rsp_status, rsp_read_value, rsp_read_position,
                        rsp_entry_count, rsp_last_of_run);
            end else begin
               due = rsp_due_q.pop_front();
               check_field("status", due.status, rsp_status);
               check_field("read_value", $signed(due.read_value), $signed(rsp_read_value));
               check_field("read_position", due.read_position, rsp_read_position);
               check_field("entry_count", due.entry_count, rsp_entry_count);
               check_field("last_of_run", due.last_of_run, rsp_last_of_run);
            end
         end
         if (push && !full) apply_command(req_command, req_element_value, req_position);
      end
      rsp_due_count <= rsp_due_q.size();
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list buffer testbench
// Drives list commands into the buffer: a directed opening over the corner
// cases, then random fill, drain and mixed sequences under three patterns of
// idling on either side. A separate monitor checks every result word.
// ----------------------------------------------------------------------------

module tb import plb_pkg::*; ();

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 115;

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   logic [2:0]              req_command;
   logic signed [VAL_W-1:0] req_element_value;
   logic [POS_W-1:0]        req_position;
   logic                    empty;
   logic                    pop = 1'b0;
   logic [1:0]              rsp_status;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [OUT_CNT_W-1:0]    rsp_read_position;
   logic [OUT_CNT_W-1:0]    rsp_entry_count;
   logic                    rsp_last_of_run;
   int                      mismatch_count;
   int                      rsp_due_count;

   int         send_idle_pct;
   int         recv_idle_pct;
   int         list_len_est;
   int         phase_sent;
   int         cycle_count;
   int         phase;
   logic [2:0] insert_ops [3];
   logic [2:0] delete_ops [3];

   positional_list_buffer DUT (.*);

   plb_list_monitor list_monitor (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(15, 0))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2:       return -32'sd1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic [2:0] command, logic signed [VAL_W-1:0] value,
                            logic [POS_W-1:0] position);
      int place;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push              <= 1'b1;
      req_command       <= command;
      req_element_value <= value;
      req_position      <= position;
      @(posedge clock iff !full);
      phase_sent++;
      case (command)
         CMD_INS_FIRST, CMD_DEL_FIRST: place = 1;
         CMD_INS_LAST:                 place = list_len_est + 1;
         CMD_DEL_LAST:                 place = list_len_est;
         default:                      place = int'(position);
      endcase
      if (command inside {CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT}) begin
         if (place >= 1 && place <= list_len_est + 1 && list_len_est < CAPACITY) list_len_est++;
      end else if (command inside {CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT}) begin
         if (place >= 1 && place <= list_len_est) list_len_est--;
      end
   endtask

   task automatic send_insert(bit allow_bad);
      logic [2:0]       command;
      logic [POS_W-1:0] position;
      command  = insert_ops[$urandom_range(2, 0)];
      position = POS_W'($urandom_range(list_len_est + 1, 1));
      if (allow_bad && $urandom_range(3, 0) == 0) begin
         position = $urandom_range(1, 0) ? '0 : POS_W'($urandom_range(255, list_len_est + 2));
      end
      send_word(command, random_value(), position);
   endtask

   task automatic send_delete(bit allow_bad);
      logic [2:0]       command;
      logic [POS_W-1:0] position;
      command  = delete_ops[$urandom_range(2, 0)];
      position = POS_W'($urandom_range((list_len_est > 0) ? list_len_est : 1, 1));
      if (allow_bad && $urandom_range(3, 0) == 0) begin
         position = $urandom_range(1, 0) ? '0 : POS_W'($urandom_range(255, list_len_est + 1));
      end
      send_word(command, random_value(), position);
   endtask

   task automatic send_noise();
      send_word(3'($urandom_range(7, 0)), random_value(), POS_W'($urandom_range(255, 0)));
   endtask

   task automatic run_episode();
      int pick;
      int span;
      pick = $urandom_range(9, 0);
      if (pick < 3) begin
         while (list_len_est < CAPACITY) send_insert(1'b0);
         repeat ($urandom_range(2, 1)) send_insert(1'b1);
         send_word(CMD_READ_ALL, random_value(), POS_W'($urandom_range(255, 0)));
      end else if (pick < 5) begin
         while (list_len_est > 0) send_delete(1'b0);
         repeat ($urandom_range(2, 1)) send_delete(1'b1);
         send_word(CMD_COUNT, random_value(), POS_W'($urandom_range(255, 0)));
      end else if (pick < 9) begin
         repeat ($urandom_range(12, 4)) begin
            span = $urandom_range(9, 0);
            if (span < 4) send_insert(span == 0);
            else if (span < 7) send_delete(span == 4);
            else if (span == 7) send_word(CMD_COUNT, random_value(), POS_W'($urandom_range(255, 0)));
            else send_word(CMD_READ_ALL, random_value(), POS_W'($urandom_range(255, 0)));
         end
      end else begin
         repeat ($urandom_range(6, 2)) send_noise();
      end
   endtask

   task automatic hold_until_drained();
      push <= 1'b0;
      @(posedge clock iff rsp_due_count == 0);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("positional_list_buffer verification failed");
      $finish;
   end

   initial begin
      insert_ops        = '{CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT};
      delete_ops        = '{CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT};
      reset             = 1'b1;
      push              = 1'b0;
      req_command       = CMD_COUNT;
      req_element_value = '0;
      req_position      = '0;
      list_len_est      = 0;
      phase_sent        = 0;
      send_idle_pct     = 29;
      recv_idle_pct     = 86;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty list first: count, read and every delete, then bad insert positions.
      send_word(CMD_COUNT, '0, '0);
      send_word(CMD_READ_ALL, '0, '0);
      send_word(CMD_DEL_FIRST, '0, '0);
      send_word(CMD_DEL_LAST, '0, '0);
      send_word(CMD_DEL_AT, '0, 8'd255);
      send_word(CMD_INS_AT, 32'sd5, 8'd0);
      send_word(CMD_INS_AT, 32'sd6, 8'd2);
      send_word(CMD_INS_FIRST, 32'sh7FFFFFFF, '0);
      send_word(CMD_INS_LAST, 32'sh80000000, 8'd255);
      send_word(CMD_INS_AT, -32'sd1, 8'd2);
      send_word(CMD_INS_AT, 32'sd0, 8'd4);
      send_word(CMD_INS_AT, 32'sd7, 8'd255);
      send_word(CMD_READ_ALL, '0, '0);
      send_word(CMD_DEL_AT, '0, 8'd0);
      send_word(CMD_DEL_AT, '0, 8'd5);
      send_word(CMD_DEL_AT, '0, 8'd2);
      send_word(CMD_DEL_FIRST, '0, '0);
      send_word(CMD_DEL_LAST, '0, '0);
      send_word(CMD_COUNT, '0, '0);
      send_word(CMD_READ_ALL, '0, '0);
      send_word(CMD_DEL_AT, '0, 8'd1);
      send_word(CMD_COUNT, '0, '0);
      hold_until_drained();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_sent = 0;
         while (phase_sent < ITEMS_PER_PHASE) run_episode();
         hold_until_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("positional_list_buffer verification clean");
      end else begin
         $display("positional_list_buffer verification failed");
      end
      $finish;
   end

endmodule
